// ===== rtl/apt_pkg.sv =====
// Shared types, widths and codes of the affine point transform.
`timescale 1ns / 1ps
`default_nettype none

package apt_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int COORD_WIDTH = 32;

    // Configuration register file
    localparam int NUM_REGS  = 6;
    localparam int IDX_WIDTH = 3;
    localparam logic [IDX_WIDTH-1:0] REG_COEF_A  = 3'd0;
    localparam logic [IDX_WIDTH-1:0] REG_COEF_B  = 3'd1;
    localparam logic [IDX_WIDTH-1:0] REG_COEF_C  = 3'd2;
    localparam logic [IDX_WIDTH-1:0] REG_COEF_D  = 3'd3;
    localparam logic [IDX_WIDTH-1:0] REG_SHIFT_X = 3'd4;
    localparam logic [IDX_WIDTH-1:0] REG_SHIFT_Y = 3'd5;

    // Request kinds
    localparam logic REQ_FORWARD = 1'b0;
    localparam logic REQ_INVERSE = 1'b1;

    // Datapath widths
    localparam int OPW   = COORD_WIDTH + 1;      // point minus translation
    localparam int PRW   = COORD_WIDTH + OPW;    // coefficient times operand
    localparam int DPW   = 2 * COORD_WIDTH;      // coefficient times coefficient
    localparam int NUMW  = PRW + 2;              // signed numerator
    localparam int DENW  = DPW + 2;              // signed determinant
    localparam int MAGW  = NUMW;                 // numerator magnitude
    localparam int DVW   = DENW;                 // divisor magnitude
    localparam int QW    = COORD_WIDTH - 1;      // quotient bits below saturation
    localparam int DIVW  = MAGW + FRAC_BITS;     // dividend
    localparam int HEADW = DIVW - QW;            // dividend bits above the quotient
    localparam int REMW  = DVW + 1;              // partial remainder
    localparam int WHOLE_LIM_BIT = COORD_WIDTH - 1 - FRAC_BITS;

    // Back pipeline: mul, sum, abs, init, QW divide steps, round, output
    localparam int BACK_DEPTH = QW + 6;

    // Request queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef logic [COORD_WIDTH-1:0] t_coord;

    localparam t_coord COEF_ONE  = t_coord'(1) << FRAC_BITS;
    localparam t_coord COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam logic signed [DENW-1:0] DEN_FWD = DENW'(1) << (2 * FRAC_BITS);

    typedef struct packed {
        t_coord a;
        t_coord b;
        t_coord c;
        t_coord d;
        t_coord tx;
        t_coord ty;
    } t_coefs;

    // Classified request handed from front to back
    typedef struct packed {
        logic           inv;
        logic           whole;
        logic [OPW-1:0] ux;
        logic [OPW-1:0] uy;
    } t_fitem;

    // Per-request flags carried beside the divider
    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic ovf_x;
        logic ovf_y;
        logic whole;
        logic sing;
    } t_side;

    typedef struct packed {
        logic [REMW-1:0] rem_x;
        logic [QW-1:0]   bits_x;
        logic [REMW-1:0] rem_y;
        logic [QW-1:0]   bits_y;
        logic [DVW-1:0]  divisor;
        t_side           side;
    } t_div_stage;

endpackage

`default_nettype wire

// ===== rtl/apt_queue.sv =====
// Short request queue between the front and the back of the transform.
`timescale 1ns / 1ps
`default_nettype none

module apt_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire apt_pkg::t_fitem i_item,
    output logic                 o_has_room,
    input  wire logic            i_pop,
    output logic                 o_has_item,
    output apt_pkg::t_fitem      o_item
);

    apt_pkg::t_fitem             r_mem [apt_pkg::QDEPTH];
    logic [apt_pkg::QPW-1:0]     r_wp;
    logic [apt_pkg::QPW-1:0]     r_rp;
    logic [apt_pkg::QCW-1:0]     r_cnt;
    logic                        push_ok;
    logic                        pop_ok;

    assign o_has_room = (r_cnt != apt_pkg::QCW'(apt_pkg::QDEPTH));
    assign o_has_item = (r_cnt != '0);
    assign o_item     = r_mem[r_rp];
    assign push_ok    = i_push && o_has_room;
    assign pop_ok     = i_pop && o_has_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop_ok) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/apt_front.sv =====
// Front end: takes a request, removes the translation for inverse requests.
`timescale 1ns / 1ps
`default_nettype none

module apt_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic            i_req_type,
    input  wire apt_pkg::t_coord i_in_x,
    input  wire apt_pkg::t_coord i_in_y,
    input  wire logic            i_round_to_integer,
    input  wire apt_pkg::t_coord i_shift_x,
    input  wire apt_pkg::t_coord i_shift_y,
    output logic                 o_push,
    input  wire logic            i_room,
    output apt_pkg::t_fitem      o_item
);

    logic                          r_vld;
    apt_pkg::t_fitem               r_item;
    apt_pkg::t_fitem               n_item;
    logic [apt_pkg::OPW-1:0]       ext_x;
    logic [apt_pkg::OPW-1:0]       ext_y;
    logic [apt_pkg::OPW-1:0]       ext_tx;
    logic [apt_pkg::OPW-1:0]       ext_ty;

    assign o_ready = !r_vld || i_room;
    assign o_push  = r_vld;
    assign o_item  = r_item;

    assign ext_x  = {i_in_x[apt_pkg::COORD_WIDTH-1], i_in_x};
    assign ext_y  = {i_in_y[apt_pkg::COORD_WIDTH-1], i_in_y};
    assign ext_tx = {i_shift_x[apt_pkg::COORD_WIDTH-1], i_shift_x};
    assign ext_ty = {i_shift_y[apt_pkg::COORD_WIDTH-1], i_shift_y};

    always_comb begin
        n_item.inv   = (i_req_type == apt_pkg::REQ_INVERSE);
        n_item.whole = i_round_to_integer;
        if (n_item.inv) begin
            n_item.ux = ext_x - ext_tx;
            n_item.uy = ext_y - ext_ty;
        end else begin
            n_item.ux = ext_x;
            n_item.uy = ext_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/apt_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, x and y lanes.
`timescale 1ns / 1ps
`default_nettype none

module apt_div (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire apt_pkg::t_div_stage i_stage,
    output apt_pkg::t_div_stage      o_stage
);

    apt_pkg::t_div_stage r_stg [apt_pkg::QW];

    // Bring in the next dividend bit, subtract when it fits, shift in the quotient bit
    function automatic apt_pkg::t_div_stage div_step(input apt_pkg::t_div_stage s);
        apt_pkg::t_div_stage     o;
        logic [apt_pkg::REMW-1:0] tx;
        logic [apt_pkg::REMW-1:0] ty;
        logic [apt_pkg::REMW-1:0] dv;
        logic                     qx;
        logic                     qy;
        o  = s;
        dv = apt_pkg::REMW'(s.divisor);
        tx = {s.rem_x[apt_pkg::REMW-2:0], s.bits_x[apt_pkg::QW-1]};
        ty = {s.rem_y[apt_pkg::REMW-2:0], s.bits_y[apt_pkg::QW-1]};
        qx = (tx >= dv);
        qy = (ty >= dv);
        o.rem_x  = qx ? tx - dv : tx;
        o.rem_y  = qy ? ty - dv : ty;
        o.bits_x = {s.bits_x[apt_pkg::QW-2:0], qx};
        o.bits_y = {s.bits_y[apt_pkg::QW-2:0], qy};
        return o;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stg[0] <= div_step(i_stage);
        end
    end

    for (genvar k = 1; k < apt_pkg::QW; k++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_stg[k] <= div_step(r_stg[k-1]);
            end
        end
    end

    assign o_stage = r_stg[apt_pkg::QW-1];

endmodule

`default_nettype wire

// ===== rtl/apt_back.sv =====
// Back end: products, numerators, determinant, division, rounding, saturation.
`timescale 1ns / 1ps
`default_nettype none

module apt_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire apt_pkg::t_coefs i_coefs,
    input  wire logic            i_q_has_item,
    input  wire apt_pkg::t_fitem i_q_item,
    output logic                 o_q_pop,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output apt_pkg::t_coord      o_out_x,
    output apt_pkg::t_coord      o_out_y,
    output logic                 o_singular
);

    localparam int W = apt_pkg::COORD_WIDTH;

    logic                            en;
    logic [apt_pkg::BACK_DEPTH-1:0]  r_vld;

    logic signed [W-1:0]             s_a, s_b, s_c, s_d, s_tx, s_ty;
    logic signed [apt_pkg::OPW-1:0]  s_ux, s_uy;
    logic signed [W-1:0]             m1c, m3c, m4c;
    logic signed [apt_pkg::OPW-1:0]  m3o, m4o;

    // mul stage
    logic signed [apt_pkg::PRW-1:0]  r_p1, r_p2, r_p3, r_p4;
    logic signed [apt_pkg::DPW-1:0]  r_p5, r_p6;
    logic                            r_m_inv, r_m_whole;
    // sum stage
    logic signed [apt_pkg::NUMW-1:0] r_nx, r_ny;
    logic signed [apt_pkg::DENW-1:0] r_den;
    logic                            r_s_inv, r_s_whole;
    // abs stage
    logic [apt_pkg::MAGW-1:0]        r_magx, r_magy;
    logic [apt_pkg::DVW-1:0]         r_md;
    apt_pkg::t_side                  r_a_side;
    // init stage
    apt_pkg::t_div_stage             r_dv_in;
    apt_pkg::t_div_stage             n_dv_in;
    apt_pkg::t_div_stage             dv_out;
    logic [apt_pkg::DIVW-1:0]        nx_div, ny_div;
    logic [apt_pkg::HEADW-1:0]       head_x, head_y;
    // round stage
    logic [W-1:0]                    r_qx, r_qy;
    apt_pkg::t_side                  r_r_side;
    logic [apt_pkg::REMW-1:0]        half_x, half_y;
    // output stage
    apt_pkg::t_coord                 r_out_x, r_out_y;
    logic                            r_sing;
    apt_pkg::t_coord                 n_out_x, n_out_y;

    function automatic apt_pkg::t_coord finish(input logic [W-1:0] q, input logic neg,
                                               input logic ovf, input logic whole);
        apt_pkg::t_coord lim;
        apt_pkg::t_coord mag;
        logic            sat;
        lim = neg ? apt_pkg::COORD_MIN : apt_pkg::COORD_MAX;
        if (whole) begin
            sat = ovf || (q >= (apt_pkg::t_coord'(1) << apt_pkg::WHOLE_LIM_BIT));
            mag = q << apt_pkg::FRAC_BITS;
        end else begin
            sat = ovf || (q >= lim);
            mag = q;
        end
        if (sat) begin
            mag = lim;
        end
        return neg ? apt_pkg::t_coord'(-mag) : mag;
    endfunction

    // the whole pipeline holds while the output register is full and not taken
    assign en      = !r_vld[apt_pkg::BACK_DEPTH-1] || i_ready;
    assign o_q_pop = en && i_q_has_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[apt_pkg::BACK_DEPTH-2:0], i_q_has_item};
        end
    end

    assign s_a  = $signed(i_coefs.a);
    assign s_b  = $signed(i_coefs.b);
    assign s_c  = $signed(i_coefs.c);
    assign s_d  = $signed(i_coefs.d);
    assign s_tx = $signed(i_coefs.tx);
    assign s_ty = $signed(i_coefs.ty);
    assign s_ux = $signed(i_q_item.ux);
    assign s_uy = $signed(i_q_item.uy);

    // forward: a*x, c*y, b*x, d*y; inverse: d*dx, c*dy, a*dy, b*dx
    assign m1c = i_q_item.inv ? s_d : s_a;
    assign m3c = i_q_item.inv ? s_a : s_b;
    assign m3o = i_q_item.inv ? s_uy : s_ux;
    assign m4c = i_q_item.inv ? s_b : s_d;
    assign m4o = i_q_item.inv ? s_ux : s_uy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1      <= m1c * s_ux;
            r_p2      <= s_c * s_uy;
            r_p3      <= m3c * m3o;
            r_p4      <= m4c * m4o;
            r_p5      <= s_a * s_d;
            r_p6      <= s_b * s_c;
            r_m_inv   <= i_q_item.inv;
            r_m_whole <= i_q_item.whole;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_m_inv) begin
                r_nx  <= apt_pkg::NUMW'(r_p1) - apt_pkg::NUMW'(r_p2);
                r_ny  <= apt_pkg::NUMW'(r_p3) - apt_pkg::NUMW'(r_p4);
                r_den <= apt_pkg::DENW'(r_p5) - apt_pkg::DENW'(r_p6);
            end else begin
                r_nx  <= apt_pkg::NUMW'(r_p1) + apt_pkg::NUMW'(r_p2)
                         + (apt_pkg::NUMW'(s_tx) <<< apt_pkg::FRAC_BITS);
                r_ny  <= apt_pkg::NUMW'(r_p3) + apt_pkg::NUMW'(r_p4)
                         + (apt_pkg::NUMW'(s_ty) <<< apt_pkg::FRAC_BITS);
                r_den <= apt_pkg::DEN_FWD;
            end
            r_s_inv   <= r_m_inv;
            r_s_whole <= r_m_whole;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_magx <= r_nx[apt_pkg::NUMW-1] ? apt_pkg::MAGW'(-r_nx) : apt_pkg::MAGW'(r_nx);
            r_magy <= r_ny[apt_pkg::NUMW-1] ? apt_pkg::MAGW'(-r_ny) : apt_pkg::MAGW'(r_ny);
            r_md   <= r_den[apt_pkg::DENW-1] ? apt_pkg::DVW'(-r_den) : apt_pkg::DVW'(r_den);
            r_a_side.neg_x <= r_nx[apt_pkg::NUMW-1] ^ r_den[apt_pkg::DENW-1];
            r_a_side.neg_y <= r_ny[apt_pkg::NUMW-1] ^ r_den[apt_pkg::DENW-1];
            r_a_side.ovf_x <= 1'b0;
            r_a_side.ovf_y <= 1'b0;
            r_a_side.whole <= r_s_whole;
            r_a_side.sing  <= r_s_inv && (r_den == '0);
        end
    end

    // a quotient at or above the top code saturates, so only QW bits are developed
    always_comb begin
        if (r_a_side.whole) begin
            nx_div = apt_pkg::DIVW'(r_magx);
            ny_div = apt_pkg::DIVW'(r_magy);
        end else begin
            nx_div = apt_pkg::DIVW'(r_magx) << apt_pkg::FRAC_BITS;
            ny_div = apt_pkg::DIVW'(r_magy) << apt_pkg::FRAC_BITS;
        end
        head_x           = nx_div[apt_pkg::DIVW-1:apt_pkg::QW];
        head_y           = ny_div[apt_pkg::DIVW-1:apt_pkg::QW];
        n_dv_in.rem_x    = apt_pkg::REMW'(head_x);
        n_dv_in.rem_y    = apt_pkg::REMW'(head_y);
        n_dv_in.bits_x   = nx_div[apt_pkg::QW-1:0];
        n_dv_in.bits_y   = ny_div[apt_pkg::QW-1:0];
        n_dv_in.divisor  = r_md;
        n_dv_in.side     = r_a_side;
        n_dv_in.side.ovf_x = (head_x >= r_md);
        n_dv_in.side.ovf_y = (head_y >= r_md);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_in <= n_dv_in;
        end
    end

    apt_div u_div (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_stage (r_dv_in),
        .o_stage (dv_out)
    );

    // round half up on the remainder: 2r >= divisor
    assign half_x = apt_pkg::REMW'(dv_out.divisor) - dv_out.rem_x;
    assign half_y = apt_pkg::REMW'(dv_out.divisor) - dv_out.rem_y;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_qx     <= {1'b0, dv_out.bits_x} + W'(dv_out.rem_x >= half_x);
            r_qy     <= {1'b0, dv_out.bits_y} + W'(dv_out.rem_y >= half_y);
            r_r_side <= dv_out.side;
        end
    end

    always_comb begin
        n_out_x = finish(r_qx, r_r_side.neg_x, r_r_side.ovf_x, r_r_side.whole);
        n_out_y = finish(r_qy, r_r_side.neg_y, r_r_side.ovf_y, r_r_side.whole);
        if (r_r_side.sing) begin
            n_out_x = '0;
            n_out_y = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_x <= n_out_x;
            r_out_y <= n_out_y;
            r_sing  <= r_r_side.sing;
        end
    end

    assign o_valid    = r_vld[apt_pkg::BACK_DEPTH-1];
    assign o_out_x    = r_out_x;
    assign o_out_y    = r_out_y;
    assign o_singular = r_sing;

endmodule

`default_nettype wire

// ===== rtl/affine_point_transform.sv =====
// Top level of the 2D affine point transform: register file, front, queue, back.
//
//  channel   handshake          payload
//  request   i_valid / o_ready  i_req_type, i_in_x, i_in_y, i_round_to_integer
//  result    o_valid / i_ready  o_out_x, o_out_y, o_singular
//  config    i_cfg_we           i_cfg_idx, i_cfg_data
//
// One point per clock while results are taken. A result passes through the front register,
// the two-entry queue and a 37-stage back pipeline set by the 31-step divider, one
// quotient bit per stage.
// Synchronous active-low reset loads the identity matrix and empties the pipeline.
// A stalled result freezes the back pipeline; the queue and front register keep
// taking requests until they fill.
`timescale 1ns / 1ps
`default_nettype none

module affine_point_transform (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [apt_pkg::IDX_WIDTH-1:0]   i_cfg_idx,
    input  wire logic [apt_pkg::COORD_WIDTH-1:0] i_cfg_data,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic                            i_req_type,
    input  wire logic [apt_pkg::COORD_WIDTH-1:0] i_in_x,
    input  wire logic [apt_pkg::COORD_WIDTH-1:0] i_in_y,
    input  wire logic                            i_round_to_integer,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [apt_pkg::COORD_WIDTH-1:0]      o_out_x,
    output logic [apt_pkg::COORD_WIDTH-1:0]      o_out_y,
    output logic                                 o_singular
);

    apt_pkg::t_coefs r_coefs;
    logic            f_push;
    apt_pkg::t_fitem f_item;
    logic            q_room;
    logic            q_has_item;
    apt_pkg::t_fitem q_item;
    logic            q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.a  <= apt_pkg::COEF_ONE;
            r_coefs.b  <= '0;
            r_coefs.c  <= '0;
            r_coefs.d  <= apt_pkg::COEF_ONE;
            r_coefs.tx <= '0;
            r_coefs.ty <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                apt_pkg::REG_COEF_A:  r_coefs.a  <= i_cfg_data;
                apt_pkg::REG_COEF_B:  r_coefs.b  <= i_cfg_data;
                apt_pkg::REG_COEF_C:  r_coefs.c  <= i_cfg_data;
                apt_pkg::REG_COEF_D:  r_coefs.d  <= i_cfg_data;
                apt_pkg::REG_SHIFT_X: r_coefs.tx <= i_cfg_data;
                apt_pkg::REG_SHIFT_Y: r_coefs.ty <= i_cfg_data;
                default: ;  // drop writes to unknown indexes
            endcase
        end
    end

    apt_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_req_type         (i_req_type),
        .i_in_x             (i_in_x),
        .i_in_y             (i_in_y),
        .i_round_to_integer (i_round_to_integer),
        .i_shift_x          (r_coefs.tx),
        .i_shift_y          (r_coefs.ty),
        .o_push             (f_push),
        .i_room             (q_room),
        .o_item             (f_item)
    );

    apt_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (f_push),
        .i_item     (f_item),
        .o_has_room (q_room),
        .i_pop      (q_pop),
        .o_has_item (q_has_item),
        .o_item     (q_item)
    );

    apt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_coefs      (r_coefs),
        .i_q_has_item (q_has_item),
        .i_q_item     (q_item),
        .o_q_pop      (q_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_singular   (o_singular)
    );

endmodule

`default_nettype wire
